[hw/rtl/aabb_collision_resolve_core_defines.svh]
// assertion macros shared by the collision resolve rtl
`ifndef AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ACR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ACR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/acr_pkg.sv]
// types, constants and helpers of the box collision resolver
package acr_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int PUSH_W    = FRAC_BITS + 1;
    localparam logic [PUSH_W-1:0] ONE_FX = PUSH_W'(1) << FRAC_BITS;

    // datapath widths
    localparam int DELTA_W = 33;
    localparam int SUM_W   = 32;
    localparam int PEN_W   = 34;
    localparam int PROD_W  = PEN_W + PUSH_W + 1;

    // saturation limits at product width
    localparam logic signed [PROD_W-1:0] SAT_HI =
        $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [PROD_W-1:0] SAT_LO =
        $signed({{(PROD_W-31){1'b1}}, {31{1'b0}}});

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [31:0] first_center_x;
        logic signed [31:0] first_center_y;
        logic        [30:0] first_half_w;
        logic        [30:0] first_half_h;
        logic signed [31:0] second_center_x;
        logic signed [31:0] second_center_y;
        logic        [30:0] second_half_w;
        logic        [30:0] second_half_h;
        logic signed [31:0] push_factor;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] first_move_x;
        logic signed [31:0] first_move_y;
        logic signed [31:0] second_move_x;
        logic signed [31:0] second_move_y;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                    hit;
        logic                    axis_x;
        logic signed [PEN_W-1:0] first_op;
        logic signed [PEN_W-1:0] second_op;
        logic [PUSH_W-1:0]       keep;
        logic [PUSH_W-1:0]       push;
    } op_t;

    // floor shift of a product and clamp to the signed 32 bit range
    function automatic logic signed [31:0] scale_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] s;
        s = v >>> FRAC_BITS;
        if (s > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return s[31:0];
    endfunction

endpackage

[hw/rtl/acr_front.sv]
// front end: accepts box pairs, finds overlap, axis and split operands
module acr_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  acr_pkg::in_item_t s_item,
    output logic             q_valid,
    input  logic             q_ready,
    output acr_pkg::op_t     q_data
);
    import acr_pkg::*;

    logic st1_valid_reg, st1_valid_next;
    logic st2_valid_reg, st2_valid_next;
    logic st2_load;

    // stage 1 payload
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic [SUM_W-1:0]          sw_reg, sh_reg;
    logic [PUSH_W-1:0]         push1_reg;

    // stage 2 payload
    logic signed [PEN_W-1:0] px_reg, py_reg;
    logic                    dx_pos_reg, dy_pos_reg;
    logic [PUSH_W-1:0]       push2_reg;

    logic [PUSH_W-1:0]       push_clamp;
    logic [DELTA_W-1:0]      abs_dx, abs_dy;
    logic signed [PEN_W-1:0] pen;
    logic                    d_pos;

    // handshake of the two front stages
    assign st2_load = !st2_valid_reg || q_ready;
    assign s_ready  = !st1_valid_reg || st2_load;
    assign q_valid  = st2_valid_reg;

    always_comb begin
        st1_valid_next = s_ready ? s_valid : st1_valid_reg;
        st2_valid_next = st2_load ? st1_valid_reg : st2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
        end
    end

    // push share clamped to 0..one
    always_comb begin
        if (s_item.push_factor[31]) begin
            push_clamp = '0;
        end else if (s_item.push_factor > $signed({{(32-PUSH_W){1'b0}}, ONE_FX})) begin
            push_clamp = ONE_FX;
        end else begin
            push_clamp = s_item.push_factor[PUSH_W-1:0];
        end
    end

    // stage 1: center deltas and half size sums
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            dx_reg    <= DELTA_W'(s_item.second_center_x) - DELTA_W'(s_item.first_center_x);
            dy_reg    <= DELTA_W'(s_item.second_center_y) - DELTA_W'(s_item.first_center_y);
            sw_reg    <= SUM_W'(s_item.first_half_w) + SUM_W'(s_item.second_half_w);
            sh_reg    <= SUM_W'(s_item.first_half_h) + SUM_W'(s_item.second_half_h);
            push1_reg <= push_clamp;
        end
    end

    // stage 2: penetration per axis
    assign abs_dx = dx_reg[DELTA_W-1] ? DELTA_W'(-dx_reg) : DELTA_W'(dx_reg);
    assign abs_dy = dy_reg[DELTA_W-1] ? DELTA_W'(-dy_reg) : DELTA_W'(dy_reg);

    always_ff @(posedge aclk) begin
        if (st2_load) begin
            px_reg     <= $signed({1'b0, abs_dx}) - $signed({2'b00, sw_reg});
            py_reg     <= $signed({1'b0, abs_dy}) - $signed({2'b00, sh_reg});
            dx_pos_reg <= !dx_reg[DELTA_W-1] && (dx_reg != '0);
            dy_pos_reg <= !dy_reg[DELTA_W-1] && (dy_reg != '0);
            push2_reg  <= push1_reg;
        end
    end

    // classify: hit, axis of least penetration, signed multiplier operands
    always_comb begin
        q_data.hit    = px_reg[PEN_W-1] && py_reg[PEN_W-1];
        q_data.axis_x = px_reg > py_reg;
        pen           = q_data.axis_x ? px_reg : py_reg;
        d_pos         = q_data.axis_x ? dx_pos_reg : dy_pos_reg;
        q_data.keep   = ONE_FX - push2_reg;
        q_data.push   = push2_reg;
        if (!q_data.hit) begin
            q_data.first_op  = '0;
            q_data.second_op = '0;
        end else if (d_pos) begin
            q_data.first_op  = pen;
            q_data.second_op = -pen;
        end else begin
            q_data.first_op  = -pen;
            q_data.second_op = pen;
        end
    end

endmodule

[hw/rtl/acr_queue.sv]
// short item queue that decouples front and back
module acr_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  acr_pkg::op_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output acr_pkg::op_t out_data
);
    import acr_pkg::*;
    `include "aabb_collision_resolve_core_defines.svh"

    op_t mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = count_reg != (Q_AW+1)'(Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (Q_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `ACR_ASSERT_NOW(a_q_bound, 1'b1, count_reg <= (Q_AW+1)'(Q_DEPTH), "queue overfilled")
    `ACR_ASSERT_NEXT(a_q_track, 1'b1, count_reg == $past(count_reg) + (Q_AW+1)'($past(push)) - (Q_AW+1)'($past(pop)), "queue count lost track")
    `ACR_ASSERT_NOW(a_q_full, !in_ready, out_valid, "full queue shows no item")

endmodule

[hw/rtl/acr_back.sv]
// back end: scales the split, saturates and presents the result
module acr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  acr_pkg::op_t      q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output acr_pkg::out_item_t m_item
);
    import acr_pkg::*;
    `include "aabb_collision_resolve_core_defines.svh"

    logic m1_valid_reg, m1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic m1_load, out_load;

    logic                     hit_reg, axis_x_reg;
    logic signed [PROD_W-1:0] prod_f_reg, prod_s_reg;
    out_item_t                out_reg;
    logic signed [31:0]       fm, sm;

    // handshake of the two back stages
    assign out_load = !m_valid_reg || m_ready;
    assign m1_load  = !m1_valid_reg || out_load;
    assign q_ready  = m1_load;
    assign m_valid  = m_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        m1_valid_next = m1_load ? q_valid : m1_valid_reg;
        m_valid_next  = out_load ? m1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m1_valid_reg <= m1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // multiply stage: penetration times each box's share
    always_ff @(posedge aclk) begin
        if (m1_load) begin
            hit_reg    <= q_data.hit;
            axis_x_reg <= q_data.axis_x;
            prod_f_reg <= PROD_W'(q_data.first_op) * PROD_W'($signed({1'b0, q_data.keep}));
            prod_s_reg <= PROD_W'(q_data.second_op) * PROD_W'($signed({1'b0, q_data.push}));
        end
    end

    // scale, saturate and route to the chosen axis
    assign fm = scale_sat(prod_f_reg);
    assign sm = scale_sat(prod_s_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.hit           <= hit_reg;
            out_reg.first_move_x  <= axis_x_reg ? fm : '0;
            out_reg.second_move_x <= axis_x_reg ? sm : '0;
            out_reg.first_move_y  <= axis_x_reg ? '0 : fm;
            out_reg.second_move_y <= axis_x_reg ? '0 : sm;
        end
    end

    `ACR_ASSERT_NOW(a_miss_zero, m_valid && !m_item.hit, (m_item.first_move_x == 0) && (m_item.first_move_y == 0) && (m_item.second_move_x == 0) && (m_item.second_move_y == 0), "miss with nonzero move")
    `ACR_ASSERT_NOW(a_one_axis, m_valid, ((m_item.first_move_x == 0) && (m_item.second_move_x == 0)) || ((m_item.first_move_y == 0) && (m_item.second_move_y == 0)), "moves on both axes")
    `ACR_ASSERT_NOW(a_opposed, m_valid, !(m_item.first_move_x[31] && m_item.second_move_x[31]) && !(m_item.first_move_y[31] && m_item.second_move_y[31]), "both boxes pushed the same way")

endmodule

[hw/rtl/aabb_collision_resolve_core.sv]
// Two-box axis-aligned overlap resolver. One box pair enters per cycle and one result
// leaves per cycle while nothing stalls; each passes two front stages for deltas and
// penetrations, one queue slot, one multiply stage and one scale/saturate output
// stage. The rate is set by the back end's two 34x18 multipliers, which take one item
// per cycle unless the output stalls. A four-entry queue separates front and back so
// either side may stall without losing items. Centres and moves are signed Q16.16,
// half sizes unsigned Q15.16; push is clamped to 0..1 and moves saturate to 32 bits.
module aabb_collision_resolve_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output acr_pkg::out_item_t m_item
);
    import acr_pkg::*;

    logic fq_valid, fq_ready;
    logic qb_valid, qb_ready;
    op_t  fq_data, qb_data;

    // classify box pairs
    acr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // decoupling queue
    acr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // compute and present displacements
    acr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
